[rtl/pinhole_project_and_cull_defines.svh]
// Assertion macros for the pinhole projection block.
// Used by rtl/pinhole_project_and_cull.sv; expects i_clk and i_rst_n in scope.
`ifndef PINHOLE_PROJECT_AND_CULL_DEFINES_SVH
`define PINHOLE_PROJECT_AND_CULL_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define PPC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a condition follows in the cycle after a trigger
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ppc_pkg.sv]
// Shared types and constants for the pinhole projection and culling block.
// No dependencies.
package ppc_pkg;

    localparam int ROT_FRAC  = 14;   // fraction bits of a rotation entry
    localparam int PIX_FRAC  = 4;    // fraction bits of a pixel value
    localparam int DIV_BITS  = 18;   // quotient bits kept before clamping
    localparam int CAM_W     = 35;   // camera frame coordinate
    localparam int NUM_W     = 52;   // focal length times coordinate
    localparam int DEN_W     = 34;   // positive depth
    localparam int PX_W      = 21;   // unsaturated pixel value
    localparam int NUM_LANES = 4;    // u1, v1, u2, v2

    typedef enum logic [2:0] {
        CFG_ROT_X     = 3'd0,
        CFG_ROT_Y     = 3'd1,
        CFG_ROT_Z     = 3'd2,
        CFG_TRANS     = 3'd3,
        CFG_FOCAL     = 3'd4,
        CFG_PRINCIPAL = 3'd5,
        CFG_IMG_SIZE  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        VERDICT_KEPT    = 2'd0,
        VERDICT_BEHIND  = 2'd1,
        VERDICT_OUTSIDE = 2'd2
    } t_verdict;

    // One stage of the shared long-division pipeline, all four lanes
    typedef struct packed {
        logic                                 valid;
        logic                                 seg;
        logic [1:0]                           front;
        logic [NUM_LANES-1:0]                 neg;
        logic [NUM_LANES-1:0]                 ovf;
        logic [1:0][DEN_W-1:0]                den;
        logic [NUM_LANES-1:0][NUM_W-1:0]      rem;
        logic [NUM_LANES-1:0][DIV_BITS-1:0]   quo;
    } t_div_stage;

endpackage

[rtl/pinhole_project_and_cull.sv]
// Pinhole projection with frustum culling in 6 + DIV_BITS = 24 register stages; one item per
// cycle sustained while the output register is empty or taken.
// The long division runs one quotient bit per register stage, which sets latency.
// The whole pipeline advances while the output register is empty or taken.
// Reset (synchronous, active low) clears all valid bits, loads a rotation that swaps the
// x and z axes, and zeroes translation, intrinsics and image size.
// Depends on ppc_pkg and pinhole_project_and_cull_defines.svh.
`include "pinhole_project_and_cull_defines.svh"

module pinhole_project_and_cull
    import ppc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [95:0] i_s_axis_tdata,
    // action
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // first_u, first_v, second_u, second_v
    output logic [63:0] o_m_axis_tdata,
    // verdict
    output logic [1:0]  o_m_axis_tuser
);

    // Configuration registers
    logic [47:0] r_rot_x, r_rot_y, r_rot_z, r_trans;
    logic [31:0] r_focal, r_principal;
    logic [23:0] r_img_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x     <= 48'h4000_0000_0000;
            r_rot_y     <= 48'h0000_4000_0000;
            r_rot_z     <= 48'h0000_0000_4000;
            r_trans     <= '0;
            r_focal     <= '0;
            r_principal <= '0;
            r_img_size  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROT_X:     r_rot_x     <= i_cfg_data;
                CFG_ROT_Y:     r_rot_y     <= i_cfg_data;
                CFG_ROT_Z:     r_rot_z     <= i_cfg_data;
                CFG_TRANS:     r_trans     <= i_cfg_data;
                CFG_FOCAL:     r_focal     <= i_cfg_data[31:0];
                CFG_PRINCIPAL: r_principal <= i_cfg_data[31:0];
                CFG_IMG_SIZE:  r_img_size  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic s_fire;
    logic r_o_valid;

    assign en              = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign s_fire          = i_s_axis_tvalid && en;

    // Stage 1: nine rotation products per endpoint
    logic                       r1_valid, r1_seg;
    logic signed [31:0]         r1_prod [2][3][3];
    logic [2:0][47:0]           rows;

    assign rows = {r_rot_z, r_rot_y, r_rot_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_seg <= i_s_axis_tuser;
            for (int e = 0; e < 2; e++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        r1_prod[e][r][c] <= $signed(rows[r][16*c +: 16])
                                          * $signed(i_s_axis_tdata[48*e + 16*c +: 16]);
                    end
                end
            end
        end
    end

    // Stage 2: sum products and add scaled translation
    logic                   r2_valid, r2_seg;
    logic signed [CAM_W-1:0] r2_cam [2][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_seg <= r1_seg;
            for (int e = 0; e < 2; e++) begin
                for (int r = 0; r < 3; r++) begin
                    r2_cam[e][r] <= CAM_W'(r1_prod[e][r][0]) + CAM_W'(r1_prod[e][r][1])
                                  + CAM_W'(r1_prod[e][r][2])
                                  + (CAM_W'($signed(r_trans[16*r +: 16])) <<< ROT_FRAC);
                end
            end
        end
    end

    // Stage 3: scale by focal length, test depth
    logic                         r3_valid, r3_seg;
    logic [1:0]                   r3_front;
    logic [1:0][DEN_W-1:0]        r3_den;
    logic signed [NUM_W-1:0]      r3_num [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_seg <= r2_seg;
            for (int e = 0; e < 2; e++) begin
                r3_front[e] <= (r2_cam[e][2] > 0);
                r3_den[e]   <= r2_cam[e][2][DEN_W-1:0];
                for (int a = 0; a < 2; a++) begin
                    r3_num[2*e + a] <= $signed({1'b0, r_focal[16*a +: 16]}) * r2_cam[e][a];
                end
            end
        end
    end

    // Stage 4: magnitude and clamp detection, then one quotient bit per stage
    t_div_stage r_div [DIV_BITS+1];
    t_div_stage n_div0;

    always_comb begin
        logic [NUM_W-1:0] mag;
        n_div0       = '0;
        n_div0.valid = r3_valid;
        n_div0.seg   = r3_seg;
        n_div0.front = r3_front;
        n_div0.den   = r3_den;
        for (int l = 0; l < NUM_LANES; l++) begin
            mag            = r3_num[l][NUM_W-1] ? NUM_W'(-r3_num[l]) : NUM_W'(r3_num[l]);
            n_div0.neg[l]  = r3_num[l][NUM_W-1];
            n_div0.rem[l]  = mag;
            n_div0.ovf[l]  = ({1'b0, mag} >= ({1'b0, r3_den[l/2], {DIV_BITS{1'b0}}}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div[0].valid <= 1'b0;
        end else if (en) begin
            r_div[0].valid <= n_div0.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0].seg   <= n_div0.seg;
            r_div[0].front <= n_div0.front;
            r_div[0].neg   <= n_div0.neg;
            r_div[0].ovf   <= n_div0.ovf;
            r_div[0].den   <= n_div0.den;
            r_div[0].rem   <= n_div0.rem;
            r_div[0].quo   <= n_div0.quo;
        end
    end

    for (genvar s = 0; s < DIV_BITS; s++) begin : g_div
        localparam int Bit = DIV_BITS - 1 - s;
        t_div_stage n_stage;

        // Subtract the shifted depth where it fits, set the quotient bit
        always_comb begin
            logic [NUM_W-1:0] trial;
            n_stage = r_div[s];
            for (int l = 0; l < NUM_LANES; l++) begin
                trial = NUM_W'(r_div[s].den[l/2]) << Bit;
                if (r_div[s].rem[l] >= trial) begin
                    n_stage.rem[l]      = r_div[s].rem[l] - trial;
                    n_stage.quo[l][Bit] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[s+1].valid <= 1'b0;
            end else if (en) begin
                r_div[s+1].valid <= n_stage.valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[s+1].seg   <= n_stage.seg;
                r_div[s+1].front <= n_stage.front;
                r_div[s+1].neg   <= n_stage.neg;
                r_div[s+1].ovf   <= n_stage.ovf;
                r_div[s+1].den   <= n_stage.den;
                r_div[s+1].rem   <= n_stage.rem;
                r_div[s+1].quo   <= n_stage.quo;
            end
        end
    end

    // Floor the signed quotient, clamp, add principal point
    t_div_stage             fin;
    logic                   r5_valid, r5_seg;
    logic [1:0]             r5_front;
    logic signed [PX_W-1:0] r5_px [NUM_LANES];

    assign fin = r_div[DIV_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= fin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DIV_BITS+1:0]        qmag;
        logic signed [DIV_BITS+1:0] qs;
        if (en) begin
            r5_seg   <= fin.seg;
            r5_front <= fin.front;
            for (int l = 0; l < NUM_LANES; l++) begin
                qmag = fin.ovf[l] ? ((DIV_BITS+2)'(1) << DIV_BITS)
                     : ((DIV_BITS+2)'(fin.quo[l])
                        + (DIV_BITS+2)'(fin.neg[l] && (fin.rem[l] != '0)));
                qs   = fin.neg[l] ? -$signed(qmag) : $signed(qmag);
                r5_px[l] <= PX_W'(qs)
                          + $signed({{(PX_W-16){1'b0}}, r_principal[16*(l%2) +: 16]});
            end
        end
    end

    // Image test, saturation and verdict into the output register
    logic [NUM_LANES-1:0] lane_in;
    logic [15:0]          sat [NUM_LANES];
    logic [1:0]           ep_in;
    logic                 front_all;
    t_verdict             n_verdict;
    logic [63:0]          n_data;
    logic                 r_o_seg;
    logic [63:0]          r_o_data;
    t_verdict             r_o_verdict;

    always_comb begin
        logic [PX_W-1:0] lim;
        for (int l = 0; l < NUM_LANES; l++) begin
            lim = PX_W'(r_img_size[12*(l%2) +: 12]) << PIX_FRAC;
            lane_in[l] = !r5_px[l][PX_W-1] && (r5_px[l] < $signed(lim));
            if (r5_px[l] > 32767) begin
                sat[l] = 16'h7FFF;
            end else if (r5_px[l] < -32768) begin
                sat[l] = 16'h8000;
            end else begin
                sat[l] = r5_px[l][15:0];
            end
        end
        ep_in     = {lane_in[2] && lane_in[3], lane_in[0] && lane_in[1]};
        front_all = r5_front[0] && (!r5_seg || r5_front[1]);
        n_data    = '0;
        if (!front_all) begin
            n_verdict = VERDICT_BEHIND;
        end else if (r5_seg) begin
            n_data    = {sat[3], sat[2], sat[1], sat[0]};
            n_verdict = (ep_in == 2'b00) ? VERDICT_OUTSIDE : VERDICT_KEPT;
        end else begin
            n_data[31:0] = {sat[1], sat[0]};
            n_verdict    = ep_in[0] ? VERDICT_KEPT : VERDICT_OUTSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_seg     <= r5_seg;
            r_o_data    <= n_data;
            r_o_verdict <= n_verdict;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_verdict;

    `PPC_ASSERT(a_verdict_code, !r_o_valid || (r_o_verdict != 2'd3), "verdict code out of range")
    `PPC_ASSERT(a_behind_zero, !(r_o_valid && r_o_verdict == VERDICT_BEHIND) || (r_o_data == '0),
        "behind-camera item carries pixel data")
    `PPC_ASSERT(a_point_second_zero, !(r_o_valid && !r_o_seg) || (r_o_data[63:32] == '0),
        "point item carries a second endpoint")
    `PPC_ASSERT_NEXT(a_accept_enters, s_fire, r1_valid, "accepted item lost at first stage")

endmodule
